/* design/bdpc_pkg.sv */
// Shared types and constants for the button debounce and press classifier.
package bdpc_pkg;

  localparam int CNT_W       = 16;  // debounce and hold counter width
  localparam int PIN_W       = 9;   // raw pin field width
  localparam int ACT_W       = 2;   // action code width per button
  localparam int MAX_VISIBLE = 9;   // buttons that reach the result fields
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  typedef enum logic [1:0] {
    OP_POLL  = 2'd0,
    OP_TICK  = 2'd1,
    OP_CLEAR = 2'd2
  } op_t;

  localparam logic [ACT_W-1:0] ACT_NONE      = 2'd0;
  localparam logic [ACT_W-1:0] ACT_SHORT     = 2'd1;
  localparam logic [ACT_W-1:0] ACT_LONG      = 2'd2;
  localparam logic [ACT_W-1:0] ACT_VERY_LONG = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VERY_LONG  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_LVL  = 2'd3;

  typedef struct packed {
    logic [CNT_W-1:0] debounce_ticks;
    logic [CNT_W-1:0] long_press_ticks;
    logic [CNT_W-1:0] very_long_press_ticks;
    logic             pressed_level;
  } cfg_t;

  // What one lane shows to the merge stage after an item.
  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic             pressed;
  } lane_view_t;

  typedef struct packed {
    logic [MAX_VISIBLE-1:0]       debounced_pressed;
    logic [ACT_W*MAX_VISIBLE-1:0] action_codes;
  } result_t;

endpackage

/* design/button_debounce_press_classifier.sv */
// Top level of the button debouncer and press classifier.
//
// Input stream (s_*): one beat per operation. s_tuser[1:0] carries the
// operation (0 poll, 1 tick, 2 clear, 3 no-op), s_tdata[8:0] the raw pin
// levels, bit i for button i, sampled on polls only.
// Output stream (m_*): exactly one beat per input beat, in order, holding
// every button's latched action (2 bits each) and debounced pressed bits.
// Configuration: cfg_we/cfg_index/cfg_data write debounce time, long and
// very long thresholds and the pressed pin level; write only while idle.
//
// The result beat is registered in the output queue and shown once the
// results before it are taken. Throughput: one beat per cycle while s_tready
// is high. Every button has its own lane, all lanes update in the accepting
// cycle, and the merge stage packs their new state into a two-entry output
// queue. s_tready falls whenever both queue entries are full, so one finished
// result may wait while the next beat is taken.
// Reset (rst, synchronous): all buttons return to the starting phase,
// counters and actions clear, registers take their defaults, queue empties.
module button_debounce_press_classifier #(
  parameter int NUM_BUTTONS = 9
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [8:0] pin_levels, zero filled above
  input  logic [1:0]  s_tuser,   // [1:0] operation
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [17:0] action_codes, [26:18] debounced_pressed
  input  logic        cfg_we,
  input  logic [bdpc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bdpc_pkg::CFG_DATA_W-1:0] cfg_data
);

  // buttons past the result fields cannot be seen, so they get no lane
  localparam int LANES = (NUM_BUTTONS < bdpc_pkg::MAX_VISIBLE) ?
                         NUM_BUTTONS : bdpc_pkg::MAX_VISIBLE;

  bdpc_pkg::cfg_t        cfg;
  bdpc_pkg::lane_view_t  views [LANES];
  bdpc_pkg::result_t     head;
  logic                  accept;
  logic                  room;

  assign s_tready = room;
  assign accept   = s_tvalid && room;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ticks        <= 16'd20;
      cfg.long_press_ticks      <= 16'd1000;
      cfg.very_long_press_ticks <= 16'd3000;
      cfg.pressed_level         <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bdpc_pkg::REG_DEBOUNCE:  cfg.debounce_ticks        <= cfg_data;
        bdpc_pkg::REG_LONG:      cfg.long_press_ticks      <= cfg_data;
        bdpc_pkg::REG_VERY_LONG: cfg.very_long_press_ticks <= cfg_data;
        bdpc_pkg::REG_PRESS_LVL: cfg.pressed_level         <= cfg_data[0];
      endcase
    end
  end

  // one lane per visible button
  for (genvar i = 0; i < LANES; i++) begin : g_lane
    bdpc_lane u_lane (
      .clk       (clk),
      .rst       (rst),
      .accept    (accept),
      .op        (s_tuser),
      .pin       (s_tdata[i]),
      .cfg       (cfg),
      .view_next (views[i])
    );
  end

  bdpc_merge #(
    .LANES (LANES)
  ) u_merge (
    .clk      (clk),
    .rst      (rst),
    .push     (accept),
    .views    (views),
    .room     (room),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .head     (head)
  );

  assign m_tdata = {5'd0, head.debounced_pressed, head.action_codes};

endmodule

/* design/bdpc_lane.sv */
// One button lane: debounce machine, release detector, hold counter, latched action.
module bdpc_lane (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   accept,
  input  logic [1:0]             op,
  input  logic                   pin,
  input  bdpc_pkg::cfg_t         cfg,
  output bdpc_pkg::lane_view_t   view_next
);

  typedef enum logic [1:0] {
    PH_START    = 2'd0,
    PH_RELEASED = 2'd1,
    PH_WAIT     = 2'd2,
    PH_PRESSED  = 2'd3
  } phase_t;

  phase_t                           phase, phase_next;
  logic [bdpc_pkg::CNT_W-1:0]       settle, settle_next;
  logic [bdpc_pkg::CNT_W-1:0]       hold, hold_next;
  logic                             awaiting, awaiting_next;
  logic [bdpc_pkg::ACT_W-1:0]       latched, latched_next;
  logic                             down;

  assign down = (pin == cfg.pressed_level);

  always_comb begin
    phase_next    = phase;
    settle_next   = settle;
    hold_next     = hold;
    awaiting_next = awaiting;
    latched_next  = latched;
    if (accept) begin
      unique case (op)
        bdpc_pkg::OP_POLL: begin
          unique case (phase)
            PH_START: begin
              if (!down) phase_next = PH_RELEASED;
            end
            PH_RELEASED: begin
              if (down) begin
                phase_next  = PH_WAIT;
                settle_next = '0;
              end
            end
            PH_WAIT: begin
              if (settle >= cfg.debounce_ticks) phase_next = down ? PH_PRESSED : PH_RELEASED;
            end
            PH_PRESSED: begin
              if (!down) begin
                phase_next  = PH_WAIT;
                settle_next = '0;
              end
            end
          endcase
          // release detector sees the updated phase
          if (latched == bdpc_pkg::ACT_NONE) begin
            if (!awaiting) begin
              if (phase_next == PH_PRESSED) awaiting_next = 1'b1;
            end else if (phase_next == PH_RELEASED) begin
              awaiting_next = 1'b0;
              priority if (hold >= cfg.very_long_press_ticks) latched_next = bdpc_pkg::ACT_VERY_LONG;
              else if (hold >= cfg.long_press_ticks) latched_next = bdpc_pkg::ACT_LONG;
              else latched_next = bdpc_pkg::ACT_SHORT;
            end
          end
        end
        bdpc_pkg::OP_TICK: begin
          if (settle < cfg.debounce_ticks) settle_next = settle + 1'b1;
          if (awaiting) begin
            if (hold != '1) hold_next = hold + 1'b1;
          end else begin
            hold_next = '0;
          end
        end
        bdpc_pkg::OP_CLEAR: begin
          latched_next = bdpc_pkg::ACT_NONE;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_START;
      settle   <= '0;
      hold     <= '0;
      awaiting <= 1'b0;
      latched  <= bdpc_pkg::ACT_NONE;
    end else begin
      phase    <= phase_next;
      settle   <= settle_next;
      hold     <= hold_next;
      awaiting <= awaiting_next;
      latched  <= latched_next;
    end
  end

  assign view_next.action  = latched_next;
  assign view_next.pressed = (phase_next == PH_PRESSED);

  // a latched action survives everything but a clear
  a_latch_holds: assert property (@(posedge clk) disable iff (rst)
    (!(accept && op == bdpc_pkg::OP_CLEAR) && latched != bdpc_pkg::ACT_NONE)
      |=> latched == $past(latched))
    else $error("latched action changed without clear");

  // pressed is only reached after the debounce wait
  a_press_via_wait: assert property (@(posedge clk) disable iff (rst)
    (phase != PH_PRESSED && phase_next == PH_PRESSED) |-> phase == PH_WAIT)
    else $error("pressed phase entered without debounce wait");

  // a tick outside a press zeroes the hold counter
  a_hold_zeroed: assert property (@(posedge clk) disable iff (rst)
    (accept && op == bdpc_pkg::OP_TICK && !awaiting) |=> hold == '0)
    else $error("hold counter not zeroed on tick while idle");

endmodule

/* design/bdpc_merge.sv */
// Merge stage: packs lane views into a result and holds it in a two-entry output queue.
module bdpc_merge #(
  parameter int LANES = 9
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  bdpc_pkg::lane_view_t  views [LANES],
  output logic                  room,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output bdpc_pkg::result_t     head
);

  bdpc_pkg::result_t packed_res;
  bdpc_pkg::result_t slot1;
  logic [1:0]        cnt;
  logic              pop;

  always_comb begin
    packed_res = '0;
    for (int i = 0; i < LANES; i++) begin
      packed_res.action_codes[bdpc_pkg::ACT_W*i +: bdpc_pkg::ACT_W] = views[i].action;
      packed_res.debounced_pressed[i] = views[i].pressed;
    end
  end

  assign room     = (cnt != 2'd2);
  assign m_tvalid = (cnt != 2'd0);
  assign pop      = m_tvalid && m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (cnt == 2'd2) head <= slot1;
      else if (push) head <= packed_res;
      if (push && cnt == 2'd2) slot1 <= packed_res;
    end else if (push) begin
      if (cnt == 2'd0) head <= packed_res;
      else slot1 <= packed_res;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> cnt != 2'd2)
    else $error("result pushed into full queue");

  a_fill_shows: assert property (@(posedge clk) disable iff (rst)
    (cnt == 2'd0 && push) |=> m_tvalid)
    else $error("result not presented after push into empty queue");

  a_drain_empties: assert property (@(posedge clk) disable iff (rst)
    (cnt == 2'd1 && pop && !push) |=> !m_tvalid)
    else $error("queue still valid after last beat taken");

endmodule

/* verif/button_debounce_press_classifier_test.sv */
// Self-checking testbench for the button debounce and press classifier.
`timescale 1ns / 1ps

module button_debounce_press_classifier_test;

  localparam int BTN             = bdpc_pkg::MAX_VISIBLE;
  localparam int ITEMS_PER_PHASE = 150;
  localparam int NUM_PHASES      = 8;
  localparam int HOLD_OFF_CYCLES = 40;
  localparam int DRAIN_LIMIT     = 20000;
  localparam int TIMEOUT_NS      = 4_000_000;  // in ns; the clock period is 4 ns

  // Operation code outside the enum: the block must leave state alone.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // Per-button debounce phases, encoded as the block keeps them.
  typedef enum logic [1:0] {
    PH_STARTING = 2'd0,
    PH_RELEASED = 2'd1,
    PH_SETTLING = 2'd2,
    PH_PRESSED  = 2'd3
  } btn_phase_t;

  // Mirror of the block: config, per-button state and the results still owed.
  class press_scoreboard;
    logic [bdpc_pkg::CNT_W-1:0] debounce_ticks;
    logic [bdpc_pkg::CNT_W-1:0] long_ticks;
    logic [bdpc_pkg::CNT_W-1:0] very_long_ticks;
    logic                       press_lvl;
    btn_phase_t                 phase    [BTN];
    logic [bdpc_pkg::CNT_W-1:0] settle   [BTN];
    logic                       awaiting [BTN];
    logic [bdpc_pkg::CNT_W-1:0] hold     [BTN];
    logic [bdpc_pkg::ACT_W-1:0] action   [BTN];
    bdpc_pkg::result_t          expected_views [$];
    int                         errors;
    int                         checked;
    int                         noted;
    int                         latched_count [4];

    function new();
      debounce_ticks  = 16'd20;
      long_ticks      = 16'd1000;
      very_long_ticks = 16'd3000;
      press_lvl       = 1'b0;
      for (int b = 0; b < BTN; b++) begin
        phase[b]    = PH_STARTING;
        settle[b]   = '0;
        awaiting[b] = 1'b0;
        hold[b]     = '0;
        action[b]   = bdpc_pkg::ACT_NONE;
      end
      errors  = 0;
      checked = 0;
      noted   = 0;
      for (int k = 0; k < 4; k++) latched_count[k] = 0;
    endfunction

    function void write_reg(logic [bdpc_pkg::CFG_IDX_W-1:0] idx,
                            logic [bdpc_pkg::CFG_DATA_W-1:0] val);
      case (idx)
        bdpc_pkg::REG_DEBOUNCE:  debounce_ticks  = val;
        bdpc_pkg::REG_LONG:      long_ticks      = val;
        bdpc_pkg::REG_VERY_LONG: very_long_ticks = val;
        bdpc_pkg::REG_PRESS_LVL: press_lvl       = val[0];
        default: ;
      endcase
    endfunction

    // Runs one operation over every button and returns the visible state after it.
    function bdpc_pkg::result_t classify_step(logic [1:0] op,
                                              logic [bdpc_pkg::PIN_W-1:0] pins);
      bdpc_pkg::result_t view;
      logic              down;
      view = '0;
      for (int b = 0; b < BTN; b++) begin
        case (op)
          bdpc_pkg::OP_POLL: begin
            down = (pins[b] == press_lvl);
            case (phase[b])
              PH_STARTING: if (!down) phase[b] = PH_RELEASED;
              PH_RELEASED: if (down) begin
                phase[b]  = PH_SETTLING;
                settle[b] = '0;
              end
              PH_SETTLING: if (settle[b] >= debounce_ticks)
                phase[b] = down ? PH_PRESSED : PH_RELEASED;
              default: if (!down) begin
                phase[b]  = PH_SETTLING;
                settle[b] = '0;
              end
            endcase
            // release detector sleeps while an action is latched
            if (action[b] == bdpc_pkg::ACT_NONE) begin
              if (!awaiting[b]) begin
                if (phase[b] == PH_PRESSED) awaiting[b] = 1'b1;
              end else if (phase[b] == PH_RELEASED) begin
                awaiting[b] = 1'b0;
                if (hold[b] >= very_long_ticks)  action[b] = bdpc_pkg::ACT_VERY_LONG;
                else if (hold[b] >= long_ticks)  action[b] = bdpc_pkg::ACT_LONG;
                else                             action[b] = bdpc_pkg::ACT_SHORT;
                latched_count[action[b]]++;
              end
            end
          end
          bdpc_pkg::OP_TICK: begin
            if (settle[b] < debounce_ticks) settle[b]++;
            if (awaiting[b]) begin
              if (hold[b] != '1) hold[b]++;
            end else begin
              hold[b] = '0;
            end
          end
          bdpc_pkg::OP_CLEAR: action[b] = bdpc_pkg::ACT_NONE;
          default: ;
        endcase
        view.action_codes[bdpc_pkg::ACT_W*b +: bdpc_pkg::ACT_W] = action[b];
        view.debounced_pressed[b] = (phase[b] == PH_PRESSED);
      end
      return view;
    endfunction

    function void note_beat(logic [1:0] op, logic [bdpc_pkg::PIN_W-1:0] pins);
      expected_views.push_back(classify_step(op, pins));
      noted++;
    endfunction

    function void check_beat(logic [31:0] tdata);
      bdpc_pkg::result_t got, want;
      got = tdata[$bits(bdpc_pkg::result_t)-1:0];
      if (expected_views.size() == 0) begin
        $error("result beat with nothing expected: tdata=%h", tdata);
        errors++;
        return;
      end
      want = expected_views.pop_front();
      checked++;
      if (got.action_codes !== want.action_codes) begin
        $error("action_codes: expected %h, actual %h", want.action_codes, got.action_codes);
        errors++;
      end
      if (got.debounced_pressed !== want.debounced_pressed) begin
        $error("debounced_pressed: expected %h, actual %h",
               want.debounced_pressed, got.debounced_pressed);
        errors++;
      end
    endfunction

    function int pending();
      return expected_views.size();
    endfunction
  endclass

  logic                            clk;
  logic                            rst;
  logic                            s_tvalid;
  logic                            s_tready;
  logic [15:0]                     s_tdata;   // [8:0] pin_levels
  logic [1:0]                      s_tuser;   // [1:0] operation
  logic                            m_tvalid;
  logic                            m_tready;
  logic [31:0]                     m_tdata;   // [17:0] action_codes, [26:18] debounced_pressed
  logic                            cfg_we;
  logic [bdpc_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [bdpc_pkg::CFG_DATA_W-1:0] cfg_data;

  press_scoreboard sb;

  // Idle controls, changed per phase by the main sequence.
  int   send_gap_pct;
  int   recv_stall_pct;
  bit   hold_off_req;
  logic level_now;                          // pressed pin level currently programmed
  logic [bdpc_pkg::PIN_W-1:0] held;         // physical button positions for random presses

  button_debounce_press_classifier i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop in case a handshake hangs.
  initial begin
    #(TIMEOUT_NS);
    $display("[FAIL] regression broken");
    $finish;
  end

  // Monitor: both sides are sampled at the rising edge, before the block's
  // own updates land. The result is checked first; since results are
  // registered, it always belongs to an earlier beat than the one going in.
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) sb.check_beat(m_tdata);
      if (s_tvalid && s_tready) sb.note_beat(s_tuser, s_tdata[bdpc_pkg::PIN_W-1:0]);
    end
  end

  // Receiver: random stalls at the phase's rate. A hold-off request keeps
  // tready low for a long stretch so the two-entry output queue fills and
  // the block has to back-pressure its input.
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
      end
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // One beat in: optional gap first, then hold valid until the block takes it.
  task automatic send(logic [1:0] op, logic [bdpc_pkg::PIN_W-1:0] pins);
    @(negedge clk);
    if ($urandom_range(99) < send_gap_pct) begin
      s_tvalid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < send_gap_pct);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {{(16-bdpc_pkg::PIN_W){1'b0}}, pins};
    do @(posedge clk); while (!s_tready);
  endtask

  // Stop offering beats and wait for every owed result, giving up at DRAIN_LIMIT.
  task automatic drain();
    int n;
    n = 0;
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (sb.pending() != 0 && n < DRAIN_LIMIT) begin
      @(posedge clk);
      n++;
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [bdpc_pkg::CFG_IDX_W-1:0] idx,
                           logic [bdpc_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    sb.write_reg(idx, val);
    if (idx == bdpc_pkg::REG_PRESS_LVL) level_now = val[0];
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic set_regs(logic [15:0] deb, logic [15:0] lng, logic [15:0] vlng, logic lvl);
    write_reg(bdpc_pkg::REG_DEBOUNCE,  deb);
    write_reg(bdpc_pkg::REG_LONG,      lng);
    write_reg(bdpc_pkg::REG_VERY_LONG, vlng);
    write_reg(bdpc_pkg::REG_PRESS_LVL, {15'd0, lvl});
  endtask

  task automatic send_ticks(int count);
    for (int k = 0; k < count; k++) send(bdpc_pkg::OP_TICK, bdpc_pkg::PIN_W'($urandom));
  endtask

  // Random beats: mostly polls and ticks over buttons that are pressed and
  // released for realistic stretches, with contact bounce on some polls,
  // occasional clears, and a share of fully random noise.
  task automatic run_random(int count, bit pressure);
    int                         r;
    logic [1:0]                 op;
    logic [bdpc_pkg::PIN_W-1:0] pins;
    for (int k = 0; k < count; k++) begin
      if (pressure && k == count / 3) hold_off_req = 1'b1;
      for (int b = 0; b < BTN; b++)
        if ($urandom_range(39) == 0) held[b] = ~held[b];
      r = $urandom_range(99);
      if (r < 10) begin
        op   = 2'($urandom_range(3));
        pins = bdpc_pkg::PIN_W'($urandom);
      end else if (r < 14) begin
        op   = bdpc_pkg::OP_CLEAR;
        pins = bdpc_pkg::PIN_W'($urandom);
      end else if (r < 16) begin
        op   = OP_UNUSED;
        pins = bdpc_pkg::PIN_W'($urandom);
      end else if (r < 56) begin
        op   = bdpc_pkg::OP_TICK;
        pins = bdpc_pkg::PIN_W'($urandom);
      end else begin
        op   = bdpc_pkg::OP_POLL;
        pins = level_now ? held : ~held;
        if ($urandom_range(9) == 0) pins[$urandom_range(bdpc_pkg::PIN_W-1)] ^= 1'b1;  // bounce
      end
      send(op, pins);
    end
  endtask

  initial begin
    sb             = new();
    rst            = 1'b1;
    s_tvalid       = 1'b0;
    s_tdata        = '0;
    s_tuser        = '0;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    hold_off_req   = 1'b0;
    level_now      = 1'b0;
    held           = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    // Directed, part one: zero debounce and zero thresholds, active-low pins.
    set_regs(16'd0, 16'd0, 16'd0, 1'b0);
    send(OP_UNUSED,          9'h1FF);   // no-op before anything happened
    send(bdpc_pkg::OP_POLL,  9'h1FF);   // all leave the starting phase
    send(bdpc_pkg::OP_POLL,  9'h000);   // all pressed -> settling
    send(bdpc_pkg::OP_POLL,  9'h000);   // zero debounce decides at once
    send(bdpc_pkg::OP_TICK,  9'h1FF);   // pins ignored on a tick
    send(bdpc_pkg::OP_POLL,  9'h1FF);
    send(bdpc_pkg::OP_POLL,  9'h1FF);   // release; zero thresholds -> very long
    send(bdpc_pkg::OP_POLL,  9'h000);   // latched, detector stays quiet
    send(bdpc_pkg::OP_CLEAR, 9'h155);
    send(OP_UNUSED,          9'h0AA);
    drain();

    // Directed, part two: active-high pins, a long press on buttons 4 and 5
    // and a very long one on 6 and 7.
    set_regs(16'd2, 16'd3, 16'd6, 1'b1);
    send(bdpc_pkg::OP_POLL, 9'h000);     // still settling from before
    send_ticks(2);
    send(bdpc_pkg::OP_POLL, 9'h0F0);     // 4..7 pressed, others released
    send_ticks(1);
    send(bdpc_pkg::OP_POLL, 9'h0C0);     // 4,5 let go
    send_ticks(2);
    send(bdpc_pkg::OP_POLL, 9'h0C0);     // 4,5 released with hold of 3 -> long
    send_ticks(4);
    send(bdpc_pkg::OP_POLL, 9'h000);
    send_ticks(2);
    send(bdpc_pkg::OP_POLL, 9'h000);     // 6,7 -> very long
    drain();

    // Maximum debounce, then lowered under a waiting button: the wait ends.
    write_reg(bdpc_pkg::REG_DEBOUNCE, 16'hFFFF);
    send(bdpc_pkg::OP_CLEAR, 9'h000);
    send(bdpc_pkg::OP_POLL, 9'h1FF);
    send_ticks(5);
    send(bdpc_pkg::OP_POLL, 9'h1FF);
    drain();
    write_reg(bdpc_pkg::REG_DEBOUNCE, 16'd2);
    send(bdpc_pkg::OP_POLL, 9'h1FF);
    drain();

    // Random phases: idle pattern cycles through none / sender / receiver /
    // both, config changes every phase including the register extremes.
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p % 4)
        0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_gap_pct = 61; recv_stall_pct = 0;  end
        2: begin send_gap_pct = 0;  recv_stall_pct = 61; end
        default: begin send_gap_pct = 28; recv_stall_pct = 28; end
      endcase
      case (p)
        0: set_regs(16'd1, 16'd4, 16'd10, 1'b0);
        1: set_regs(16'd0, 16'd0, 16'd0, 1'b1);
        2: set_regs(16'd3, 16'd6, 16'd15, 1'b0);
        3: set_regs(16'd2, 16'hFFFF, 16'hFFFF, 1'b1);  // everything short
        4: set_regs(16'd0, 16'd5, 16'd3, 1'b0);        // very long below long
        5: set_regs(16'd1, 16'd2, 16'd25, 1'b1);
        default: set_regs(16'($urandom_range(4)), 16'($urandom_range(10)),
                          16'($urandom_range(30)), 1'($urandom_range(1)));
      endcase
      run_random(ITEMS_PER_PHASE, p == 0);
      drain();
    end

    if (sb.pending() != 0) begin
      $error("%0d expected results never arrived", sb.pending());
      sb.errors++;
    end
    $display("Checked %0d results for %0d beats: directed presses, debounce edges, %0d random phases.",
             sb.checked, sb.noted, NUM_PHASES);
    $display("Presses classified: short %0d, long %0d, very long %0d.",
             sb.latched_count[bdpc_pkg::ACT_SHORT], sb.latched_count[bdpc_pkg::ACT_LONG],
             sb.latched_count[bdpc_pkg::ACT_VERY_LONG]);
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* sim.f */
design/bdpc_pkg.sv
design/bdpc_lane.sv
design/bdpc_merge.sv
design/button_debounce_press_classifier.sv
verif/button_debounce_press_classifier_test.sv
